FILE: rtl/core/odr_pkg.sv
// ----------------------------------------------------------------------------
// odr_pkg
// Shared types, codes and helpers of the odometry ratio calibrator.
// ----------------------------------------------------------------------------
package odr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [31:0] DURATION_RST = 32'd10000000;
  localparam logic [16:0] FORGET_RST   = 17'd6554;
  localparam logic [15:0] FLOOR_RST    = 16'd655;
  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

  localparam logic [1:0] CFG_DURATION = 2'd0;
  localparam logic [1:0] CFG_FORGET   = 2'd1;
  localparam logic [1:0] CFG_FLOOR    = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_TIME   = 5'd2;
  localparam logic [4:0] OP_SQ_RX  = 5'd3;
  localparam logic [4:0] OP_SQ_RY  = 5'd4;
  localparam logic [4:0] OP_SQ_EX  = 5'd5;
  localparam logic [4:0] OP_SQ_EY  = 5'd6;
  localparam logic [4:0] OP_VREF   = 5'd7;
  localparam logic [4:0] OP_VEST   = 5'd8;
  localparam logic [4:0] OP_RED    = 5'd9;
  localparam logic [4:0] OP_Q      = 5'd10;
  localparam logic [4:0] OP_BAS    = 5'd11;
  localparam logic [4:0] OP_BAS0   = 5'd12;
  localparam logic [4:0] OP_ACC    = 5'd13;
  localparam logic [4:0] OP_EMA_RA = 5'd14;
  localparam logic [4:0] OP_EMA_RB = 5'd15;
  localparam logic [4:0] OP_EMA_RW = 5'd16;
  localparam logic [4:0] OP_EMA_BA = 5'd17;
  localparam logic [4:0] OP_EMA_BB = 5'd18;
  localparam logic [4:0] OP_EMA_BW = 5'd19;
  localparam logic [4:0] OP_FIN    = 5'd20;
  localparam logic [4:0] OP_AVGR   = 5'd21;
  localparam logic [4:0] OP_AVGB   = 5'd22;
  localparam logic [4:0] OP_OUT    = 5'd23;

  localparam logic [2:0] DIV_RED  = 3'd0;
  localparam logic [2:0] DIV_Q    = 3'd1;
  localparam logic [2:0] DIV_BAS  = 3'd2;
  localparam logic [2:0] DIV_AVGR = 3'd3;
  localparam logic [2:0] DIV_AVGB = 3'd4;

  typedef struct packed {
    logic [4:0] op;
    logic       div_go;
    logic       sqrt_go;
    logic [2:0] div_sel;
  } odr_cmd_t;

  typedef struct packed {
    logic running;
    logic started;
    logic pass;
    logic red_zero;
    logic count_nz;
    logic dirty;
    logic done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } odr_stat_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    abs32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    if (!neg) begin
      sat_mag = (mag > {32'd0, S32_MAX}) ? S32_MAX : mag[31:0];
    end else begin
      sat_mag = (mag > {32'd0, S32_MIN}) ? S32_MIN : (~mag[31:0] + 32'd1);
    end
  endfunction

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    if (v > $signed({34'd0, S32_MAX})) begin
      sat66 = S32_MAX;
    end else if (v < $signed({{34{1'b1}}, S32_MIN})) begin
      sat66 = S32_MIN;
    end else begin
      sat66 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/odometry_ratio_calibrator.sv
// ----------------------------------------------------------------------------
// odometry_ratio_calibrator
// Forms speed and turn-rate ratios between two odometry sources, averages them.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid/in_ready      timestamps, velocities
//   out      source     out_valid/out_ready    averages, moving averages, end
//   cfg      sink       cfg_valid/cfg_ready    register index, data
//
// One sample at a time: the first only sets the start, one below the floor with
// no result ends after the reference root, a full update takes two roots and
// five quotients on the shared radix-2 divider, four if the reduction ratio is 0.
// Reset leaves config registers at defaults; no clearing pass.
// A pending result does not hold off the next request; the sequencer waits
// only when a new result is due and the output register is still full.
// ----------------------------------------------------------------------------
module odometry_ratio_calibrator
  import odr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] time_est_us_i,
  input  logic [47:0] time_ref_us_i,
  input  logic [31:0] est_vx_i,
  input  logic [31:0] est_vy_i,
  input  logic [31:0] est_wz_i,
  input  logic [31:0] ref_vx_i,
  input  logic [31:0] ref_vy_i,
  input  logic [31:0] ref_wz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] avg_reduction_o,
  output logic [31:0] ema_reduction_o,
  output logic [31:0] avg_baseline_o,
  output logic [31:0] ema_baseline_o,
  output logic        finished_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  odr_cmd_t  cmd;
  odr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  odr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  odr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .time_est_us_i   (time_est_us_i),
    .time_ref_us_i   (time_ref_us_i),
    .est_vx_i        (est_vx_i),
    .est_vy_i        (est_vy_i),
    .est_wz_i        (est_wz_i),
    .ref_vx_i        (ref_vx_i),
    .ref_vy_i        (ref_vy_i),
    .ref_wz_i        (ref_wz_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .avg_reduction_o (avg_reduction_o),
    .ema_reduction_o (ema_reduction_o),
    .avg_baseline_o  (avg_baseline_o),
    .ema_baseline_o  (ema_baseline_o),
    .finished_o      (finished_o)
  );

endmodule

FILE: rtl/core/odr_div.sv
// ----------------------------------------------------------------------------
// odr_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module odr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] n_q, n_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh     = {rem_q, n_q[63]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = 32'(sh - {1'b0, den_q});
        n_d   = {n_q[62:0], 1'b1};
      end else begin
        rem_d = sh[31:0];
        n_d   = {n_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

FILE: rtl/core/odr_sqrt.sv
// ----------------------------------------------------------------------------
// odr_sqrt
// Integer square root of a 64-bit word, one root bit a cycle.
// ----------------------------------------------------------------------------
module odr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] n_q, n_d;
  logic [35:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [35:0] sh;
  logic [35:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    sh     = {rem_q[33:0], n_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      n_d = {n_q[61:0], 2'b00};
      if (sh >= trial) begin
        rem_d  = sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = sh;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/odr_dp.sv
// ----------------------------------------------------------------------------
// odr_dp
// Datapath: sample latch, magnitudes, ratios, sums, moving averages, result.
// ----------------------------------------------------------------------------
module odr_dp
  import odr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  odr_cmd_t    cmd_i,
  output odr_stat_t   stat_o,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [47:0] time_est_us_i,
  input  logic [47:0] time_ref_us_i,
  input  logic [31:0] est_vx_i,
  input  logic [31:0] est_vy_i,
  input  logic [31:0] est_wz_i,
  input  logic [31:0] ref_vx_i,
  input  logic [31:0] ref_vy_i,
  input  logic [31:0] ref_wz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] avg_reduction_o,
  output logic [31:0] ema_reduction_o,
  output logic [31:0] avg_baseline_o,
  output logic [31:0] ema_baseline_o,
  output logic        finished_o
);

  logic [31:0] duration_q;
  logic [16:0] forget_q;
  logic [15:0] floor_q;

  logic        started_q, running_q, done_q, dirty_q, pass_q;
  logic [47:0] start_q, t_q;
  logic [31:0] evx_q, evy_q, ewz_q, rvx_q, rvy_q, rwz_q;
  logic [31:0] vref_q, vest_q, red_q, q_q, bas_q;
  logic [63:0] sum_r_q, sum_b_q;
  logic [31:0] count_q;
  logic [31:0] ema_r_q, ema_b_q, avg_r_q, avg_b_q;
  logic signed [65:0] prod_q, acc_q;
  logic        out_valid_q, fin_q;
  logic [31:0] o_avg_r_q, o_ema_r_q, o_avg_b_q, o_ema_b_q;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_d;
  logic signed [65:0] sum_ab;
  logic signed [65:0] ema_sh;
  logic [16:0] f_w, w0;
  logic [47:0] elapsed;
  logic [48:0] t_sum;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done, sqrt_done;
  logic [63:0] quo;
  logic [31:0] root;

  assign f_w    = (forget_q > WEIGHT_ONE) ? WEIGHT_ONE : forget_q;
  assign w0     = WEIGHT_ONE - f_w;
  assign t_sum  = {1'b0, time_est_us_i} + {1'b0, time_ref_us_i};
  assign elapsed = (t_q >= start_q) ? (t_q - start_q) : '0;
  assign sum_ab = acc_q + prod_q;
  assign ema_sh = (sum_ab + 66'sd32768) >>> 16;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_SQ_RX: begin ma = {1'b0, abs32(rvx_q)}; mb = {1'b0, abs32(rvx_q)}; end
      OP_SQ_RY: begin ma = {1'b0, abs32(rvy_q)}; mb = {1'b0, abs32(rvy_q)}; end
      OP_SQ_EX: begin ma = {1'b0, abs32(evx_q)}; mb = {1'b0, abs32(evx_q)}; end
      OP_SQ_EY: begin ma = {1'b0, abs32(evy_q)}; mb = {1'b0, abs32(evy_q)}; end
      OP_EMA_RA: begin ma = {16'd0, w0};  mb = {ema_r_q[31], ema_r_q}; end
      OP_EMA_RB: begin ma = {16'd0, f_w}; mb = {red_q[31], red_q}; end
      OP_EMA_BA: begin ma = {16'd0, w0};  mb = {ema_b_q[31], ema_b_q}; end
      OP_EMA_BB: begin ma = {16'd0, f_w}; mb = {bas_q[31], bas_q}; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_d = ma * mb;
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.div_sel)
      DIV_RED:  begin div_num = {32'd0, vest_q} << FRAC_BITS;        div_den = vref_q; end
      DIV_Q:    begin div_num = {32'd0, abs32(ewz_q)} << FRAC_BITS; div_den = rwz_q; end
      DIV_BAS:  begin div_num = {32'd0, abs32(q_q)} << FRAC_BITS;   div_den = red_q; end
      DIV_AVGR: begin
        div_num = sum_r_q[63] ? (~sum_r_q + 64'd1) : sum_r_q;
        div_den = count_q;
      end
      DIV_AVGB: begin
        div_num = sum_b_q[63] ? (~sum_b_q + 64'd1) : sum_b_q;
        div_den = count_q;
      end
      default: begin div_num = '0; div_den = '0; end
    endcase
  end

  odr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  odr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .rad_i   (sum_ab[63:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q  <= DURATION_RST;
      forget_q    <= FORGET_RST;
      floor_q     <= FLOOR_RST;
      started_q   <= 1'b0;
      running_q   <= 1'b1;
      start_q     <= '0;
      sum_r_q     <= '0;
      sum_b_q     <= '0;
      count_q     <= '0;
      ema_r_q     <= '0;
      ema_b_q     <= '0;
      done_q      <= 1'b0;
      dirty_q     <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DURATION: duration_q <= cfg_data_i;
          CFG_FORGET:   forget_q   <= cfg_data_i[16:0];
          CFG_FLOOR:    floor_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_TIME: begin
          if (running_q && !started_q) begin
            start_q   <= t_q;
            started_q <= 1'b1;
          end
          done_q  <= elapsed >= {16'd0, duration_q};
          dirty_q <= 1'b0;
        end
        OP_VREF: begin
          pass_q <= (root > {16'd0, floor_q}) &&
                    ($signed(rwz_q) > $signed({16'd0, floor_q}));
        end
        OP_ACC: begin
          dirty_q <= 1'b1;
          if (count_q != '1) begin
            sum_r_q <= sum_r_q + {{32{red_q[31]}}, red_q};
            sum_b_q <= sum_b_q + {{32{bas_q[31]}}, bas_q};
            count_q <= count_q + 32'd1;
          end
        end
        OP_EMA_RW: ema_r_q <= sat66(ema_sh);
        OP_EMA_BW: ema_b_q <= sat66(ema_sh);
        OP_FIN: running_q <= running_q && !done_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_LOAD: begin
        t_q   <= t_sum[48:1];
        evx_q <= est_vx_i;
        evy_q <= est_vy_i;
        ewz_q <= est_wz_i;
        rvx_q <= ref_vx_i;
        rvy_q <= ref_vy_i;
        rwz_q <= ref_wz_i;
      end
      OP_SQ_RY, OP_SQ_EY, OP_EMA_RB, OP_EMA_BB: acc_q <= prod_q;
      OP_SQ_RX, OP_SQ_EX, OP_EMA_RA, OP_EMA_BA: acc_q <= '0;
      OP_VREF: vref_q <= root;
      OP_VEST: vest_q <= root;
      OP_RED:  red_q  <= (quo > {32'd0, S32_MAX}) ? S32_MAX : quo[31:0];
      OP_Q:    q_q    <= sat_mag(ewz_q[31], quo);
      OP_BAS:  bas_q  <= sat_mag(q_q[31], quo);
      OP_BAS0: bas_q  <= (q_q == '0) ? '0 : (q_q[31] ? S32_MIN : S32_MAX);
      OP_FIN: begin
        if (count_q == '0) begin
          avg_r_q <= '0;
          avg_b_q <= '0;
        end
      end
      OP_AVGR: avg_r_q <= sat_mag(sum_r_q[63], quo);
      OP_AVGB: avg_b_q <= sat_mag(sum_b_q[63], quo);
      OP_OUT: begin
        o_avg_r_q <= avg_r_q;
        o_ema_r_q <= ema_r_q;
        o_avg_b_q <= avg_b_q;
        o_ema_b_q <= ema_b_q;
        fin_q     <= done_q;
      end
      default: ;
    endcase
  end

  assign stat_o.running   = running_q;
  assign stat_o.started   = started_q;
  assign stat_o.pass      = pass_q;
  assign stat_o.red_zero  = (red_q == '0);
  assign stat_o.count_nz  = (count_q != '0);
  assign stat_o.dirty     = dirty_q;
  assign stat_o.done      = done_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign avg_reduction_o = o_avg_r_q;
  assign ema_reduction_o = o_ema_r_q;
  assign avg_baseline_o  = o_avg_b_q;
  assign ema_baseline_o  = o_ema_b_q;
  assign finished_o      = fin_q;

  a_stop_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> $past(done_q))
    else $error("running cleared without window end");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> count_q >= $past(count_q))
    else $error("sample count went down");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

endmodule

FILE: rtl/core/odr_ctrl.sv
// ----------------------------------------------------------------------------
// odr_ctrl
// Sequencer: steps the datapath through one sample.
// ----------------------------------------------------------------------------
module odr_ctrl
  import odr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  odr_stat_t stat_i,
  output odr_cmd_t  cmd_o
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_TIME    = 5'd1;
  localparam logic [4:0] ST_SQ_RX   = 5'd2;
  localparam logic [4:0] ST_SQ_RY   = 5'd3;
  localparam logic [4:0] ST_SQRT_R  = 5'd4;
  localparam logic [4:0] ST_WAIT_SR = 5'd5;
  localparam logic [4:0] ST_PASS    = 5'd6;
  localparam logic [4:0] ST_SQ_EX   = 5'd7;
  localparam logic [4:0] ST_SQ_EY   = 5'd8;
  localparam logic [4:0] ST_SQRT_E  = 5'd9;
  localparam logic [4:0] ST_WAIT_SE = 5'd10;
  localparam logic [4:0] ST_DIV_RED = 5'd11;
  localparam logic [4:0] ST_WT_RED  = 5'd12;
  localparam logic [4:0] ST_DIV_Q   = 5'd13;
  localparam logic [4:0] ST_WT_Q    = 5'd14;
  localparam logic [4:0] ST_DIV_BAS = 5'd15;
  localparam logic [4:0] ST_WT_BAS  = 5'd16;
  localparam logic [4:0] ST_BAS0    = 5'd17;
  localparam logic [4:0] ST_ACC     = 5'd18;
  localparam logic [4:0] ST_EMA_RA  = 5'd19;
  localparam logic [4:0] ST_EMA_RB  = 5'd20;
  localparam logic [4:0] ST_EMA_RW  = 5'd21;
  localparam logic [4:0] ST_EMA_BA  = 5'd22;
  localparam logic [4:0] ST_EMA_BB  = 5'd23;
  localparam logic [4:0] ST_EMA_BW  = 5'd24;
  localparam logic [4:0] ST_FIN     = 5'd25;
  localparam logic [4:0] ST_DIV_AR  = 5'd26;
  localparam logic [4:0] ST_WT_AR   = 5'd27;
  localparam logic [4:0] ST_DIV_AB  = 5'd28;
  localparam logic [4:0] ST_WT_AB   = 5'd29;
  localparam logic [4:0] ST_OUT     = 5'd30;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.div_go  = 1'b0;
    cmd_o.sqrt_go = 1'b0;
    cmd_o.div_sel = DIV_RED;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_TIME;
        end
      end
      ST_TIME: begin
        cmd_o.op = OP_TIME;
        state_d  = (stat_i.running && stat_i.started) ? ST_SQ_RX : ST_IDLE;
      end
      ST_SQ_RX: begin cmd_o.op = OP_SQ_RX; state_d = ST_SQ_RY; end
      ST_SQ_RY: begin cmd_o.op = OP_SQ_RY; state_d = ST_SQRT_R; end
      ST_SQRT_R: begin cmd_o.sqrt_go = 1'b1; state_d = ST_WAIT_SR; end
      ST_WAIT_SR: begin
        if (stat_i.sqrt_done) begin
          cmd_o.op = OP_VREF;
          state_d  = ST_PASS;
        end
      end
      ST_PASS:  state_d = stat_i.pass ? ST_SQ_EX : ST_FIN;
      ST_SQ_EX: begin cmd_o.op = OP_SQ_EX; state_d = ST_SQ_EY; end
      ST_SQ_EY: begin cmd_o.op = OP_SQ_EY; state_d = ST_SQRT_E; end
      ST_SQRT_E: begin cmd_o.sqrt_go = 1'b1; state_d = ST_WAIT_SE; end
      ST_WAIT_SE: begin
        if (stat_i.sqrt_done) begin
          cmd_o.op = OP_VEST;
          state_d  = ST_DIV_RED;
        end
      end
      ST_DIV_RED: begin
        cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_RED; state_d = ST_WT_RED;
      end
      ST_WT_RED: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_RED;
          state_d  = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_Q; state_d = ST_WT_Q;
      end
      ST_WT_Q: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_Q;
          state_d  = stat_i.red_zero ? ST_BAS0 : ST_DIV_BAS;
        end
      end
      ST_DIV_BAS: begin
        cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_BAS; state_d = ST_WT_BAS;
      end
      ST_WT_BAS: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_BAS;
          state_d  = ST_ACC;
        end
      end
      ST_BAS0:   begin cmd_o.op = OP_BAS0;   state_d = ST_ACC; end
      ST_ACC:    begin cmd_o.op = OP_ACC;    state_d = ST_EMA_RA; end
      ST_EMA_RA: begin cmd_o.op = OP_EMA_RA; state_d = ST_EMA_RB; end
      ST_EMA_RB: begin cmd_o.op = OP_EMA_RB; state_d = ST_EMA_RW; end
      ST_EMA_RW: begin cmd_o.op = OP_EMA_RW; state_d = ST_EMA_BA; end
      ST_EMA_BA: begin cmd_o.op = OP_EMA_BA; state_d = ST_EMA_BB; end
      ST_EMA_BB: begin cmd_o.op = OP_EMA_BB; state_d = ST_EMA_BW; end
      ST_EMA_BW: begin cmd_o.op = OP_EMA_BW; state_d = ST_FIN; end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        if (!stat_i.dirty && !stat_i.done) begin
          state_d = ST_IDLE;
        end else begin
          state_d = stat_i.count_nz ? ST_DIV_AR : ST_OUT;
        end
      end
      ST_DIV_AR: begin
        cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_AVGR; state_d = ST_WT_AR;
      end
      ST_WT_AR: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_AVGR;
          state_d  = ST_DIV_AB;
        end
      end
      ST_DIV_AB: begin
        cmd_o.div_go = 1'b1; cmd_o.div_sel = DIV_AVGB; state_d = ST_WT_AB;
      end
      ST_WT_AB: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_AVGB;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: verif/odometry_ratio_calibrator_tb.sv
// ----------------------------------------------------------------------------
// odometry_ratio_calibrator_tb
// Self-checking bench: paired odometry requests go through a queued driver, a
// built-in fixed-point predictor works out the averages, and a monitor checks
// every result against them under random stalls on both channels.
// ----------------------------------------------------------------------------
module odometry_ratio_calibrator_tb
  import odr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned CALM_AFTER  = 880;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned SETTLE      = 600;

  typedef struct packed {
    logic [47:0] t_est;
    logic [47:0] t_ref;
    logic [31:0] evx;
    logic [31:0] evy;
    logic [31:0] ewz;
    logic [31:0] rvx;
    logic [31:0] rvy;
    logic [31:0] rwz;
  } sample_t;

  typedef struct packed {
    logic [31:0] avg_red;
    logic [31:0] ema_red;
    logic [31:0] avg_bas;
    logic [31:0] ema_bas;
    logic        fin;
  } ratios_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [47:0] time_est_us_i = '0;
  logic [47:0] time_ref_us_i = '0;
  logic [31:0] est_vx_i = '0;
  logic [31:0] est_vy_i = '0;
  logic [31:0] est_wz_i = '0;
  logic [31:0] ref_vx_i = '0;
  logic [31:0] ref_vy_i = '0;
  logic [31:0] ref_wz_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] avg_reduction_o;
  logic [31:0] ema_reduction_o;
  logic [31:0] avg_baseline_o;
  logic [31:0] ema_baseline_o;
  logic        finished_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  odometry_ratio_calibrator DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  sample_t     sample_q[$];
  ratios_t     ratios_q[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;

  // predictor state
  logic [31:0]  p_duration;
  logic [16:0]  p_forget;
  logic [15:0]  p_floor;
  bit           p_started;
  bit           p_running;
  logic [48:0]  p_start;
  longint       p_sum_red;
  longint       p_sum_bas;
  int unsigned  p_count;
  longint       p_ema_red;
  longint       p_ema_bas;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned speed(logic [31:0] x, logic [31:0] y);
    longint ax = longint'($signed(x));
    longint ay = longint'($signed(y));
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return root64(longint'(ax * ax) + longint'(ay * ay));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint prev, longint now);
    longint f = (p_forget > WEIGHT_ONE) ? 65536 : longint'(p_forget);
    longint acc = (65536 - f) * prev + f * now + 32768;
    return clamp32(acc >>> 16);
  endfunction

  task automatic predict_ratios(sample_t s);
    logic [48:0]     t;
    logic [48:0]     elapsed;
    longint unsigned vref, vest, rq;
    longint          red, q, bas, flr;
    bit              dirty, done;
    ratios_t         r;
    dirty = 0;
    done = 0;
    if (!p_running) return;
    t = ({1'b0, s.t_est} + {1'b0, s.t_ref}) >> 1;
    if (!p_started) begin
      p_start = t;
      p_started = 1;
      return;
    end
    elapsed = (t >= p_start) ? t - p_start : '0;
    flr = longint'(p_floor);
    vref = speed(s.rvx, s.rvy);
    if (vref > flr && longint'($signed(s.rwz)) > flr) begin
      vest = speed(s.evx, s.evy);
      rq = (vest << FRAC_BITS_DEF) / vref;
      red = (rq > 64'd2147483647) ? 64'sd2147483647 : longint'(rq);
      q = clamp32((longint'($signed(s.ewz)) * 65536) / longint'($signed(s.rwz)));
      if (red != 0) bas = clamp32((q * 65536) / red);
      else bas = (q > 0) ? 64'sd2147483647 : ((q < 0) ? -64'sd2147483648 : 0);
      if (p_count != 32'hFFFF_FFFF) begin
        p_sum_red += red;
        p_sum_bas += bas;
        p_count++;
      end
      p_ema_red = blend(p_ema_red, red);
      p_ema_bas = blend(p_ema_bas, bas);
      dirty = 1;
    end
    if (elapsed >= {17'd0, p_duration}) begin
      p_running = 0;
      done = 1;
    end
    if (!dirty && !done) return;
    r.avg_red = (p_count != 0) ? 32'(clamp32(p_sum_red / longint'(p_count))) : '0;
    r.avg_bas = (p_count != 0) ? 32'(clamp32(p_sum_bas / longint'(p_count))) : '0;
    r.ema_red = 32'(p_ema_red);
    r.ema_bas = 32'(p_ema_bas);
    r.fin = done;
    ratios_q.push_back(r);
  endtask

  task automatic post(sample_t s);
    predict_ratios(s);
    sample_q.push_back(s);
  endtask

  task automatic post_vel(logic [31:0] evx, logic [31:0] evy, logic [31:0] ewz,
                          logic [31:0] rvx, logic [31:0] rvy, logic [31:0] rwz);
    sample_t s;
    s.t_est = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    s.t_ref = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    s.evx = evx; s.evy = evy; s.ewz = ewz;
    s.rvx = rvx; s.rvy = rvy; s.rwz = rwz;
    post(s);
  endtask

  function automatic logic [31:0] signed_upto(int unsigned lo, int unsigned hi);
    logic [31:0] v = $urandom_range(hi, lo);
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  task automatic post_random();
    int unsigned k = $urandom_range(99, 0);
    int unsigned fl = p_floor;
    int unsigned span = 1 << $urandom_range(24, 4);
    if (k < 75) begin
      post_vel(signed_upto(0, span), signed_upto(0, span), signed_upto(0, span),
               signed_upto(fl + 1, fl + span), signed_upto(0, span),
               $urandom_range(fl + span, fl + 1));
    end else begin
      post_vel($urandom, $urandom, $urandom, $urandom, $urandom,
               (k < 90) ? $urandom_range(32'h7FFF_FFFF, fl + 1) : $urandom);
    end
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || ratios_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DURATION) p_duration = data;
    else if (idx == CFG_FORGET) p_forget = data[16:0];
    else if (idx == CFG_FLOOR) p_floor = data[15:0];
  endtask

  // stimulus
  initial begin
    sample_t s;
    p_duration = DURATION_RST;
    p_forget = FORGET_RST;
    p_floor = FLOOR_RST;
    p_started = 0;
    p_running = 1;
    p_start = '0;
    p_sum_red = 0;
    p_sum_bas = 0;
    p_count = 0;
    p_ema_red = 0;
    p_ema_bas = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    write_reg(CFG_DURATION, 32'hFFFF_FFFF);
    write_reg(CFG_FORGET, 32'd6554);
    write_reg(CFG_FLOOR, 32'd655);

    // start time at the top so later timestamps never run the window out
    s = '0;
    s.t_est = 48'hFFFF_FFFF_FFFF;
    s.t_ref = 48'hFFFF_FFFF_FFFF;
    post(s);
    s = '0;
    post(s);
    post_vel(0, 0, 0, 655, 0, 656);
    post_vel(0, 0, 0, 656, 0, 655);
    post_vel(32'h10000, 0, 32'h10000, 656, 0, 656);
    post_vel(0, 0, 32'h20000, 32'h10000, 0, 32'h10000);
    post_vel(0, 0, 32'hFFFE_0000, 32'h10000, 0, 32'h10000);
    post_vel(0, 0, 0, 32'h10000, 0, 32'h10000);
    post_vel(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 700, 0, 700);
    post_vel(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 700, 700);
    post_vel(32'h10000, 32'h10000, 32'h10000,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    post_vel(32'hFFFF_0000, 32'h18000, 32'hFFFF_8000, 32'hFFFF_0000, 32'h8000,
             32'h18000);
    post_vel(32'h10000, 0, 32'h10000, 32'h10000, 0, 32'h8000_0000);
    post_vel(32'h10000, 0, 32'h10000, 32'h10000, 0, 32'hFFFF_FFFF);
    post_vel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    post_vel(1, 1, 1, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    repeat (280) post_random();
    wait_idle();

    write_reg(CFG_FORGET, 32'd0);
    write_reg(CFG_FLOOR, 32'd0);
    post_vel(5, 0, 5, 1, 0, 1);
    post_vel(5, 0, 5, 0, 0, 1);
    repeat (150) post_random();
    wait_idle();

    write_reg(CFG_FORGET, 32'd65536);
    write_reg(CFG_FLOOR, 32'd65535);
    post_vel(32'h20000, 0, 32'h20000, 32'hFFFF, 0, 32'h10000);
    repeat (150) post_random();
    wait_idle();

    write_reg(CFG_FORGET, 32'h1FFFF);
    write_reg(CFG_FLOOR, 32'd1);
    write_reg(CFG_DURATION, 32'd12345678);
    repeat (150) post_random();
    wait_idle();

    write_reg(CFG_FORGET, 32'd32768);
    write_reg(CFG_FLOOR, 32'd655);
    repeat (160) post_random();
    wait_idle();

    write_reg(CFG_DURATION, 32'd0);
    post_vel(0, 0, 0, 0, 0, 0);
    repeat (4) post_random();
    wait_idle();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) sent <= sent + 1;
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (sent < CALM_AFTER && $urandom_range(7, 0) == 0) begin
          gap_left <= $urandom_range(10, 0);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          sample_t s;
          s = sample_q.pop_front();
          time_est_us_i <= s.t_est;
          time_ref_us_i <= s.t_ref;
          est_vx_i <= s.evx;
          est_vy_i <= s.evy;
          est_wz_i <= s.ewz;
          ref_vx_i <= s.rvx;
          ref_vy_i <= s.rvy;
          ref_wz_i <= s.rwz;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result acceptance, with one long hold-off to back the block up
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          held = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!held && sent >= HOLD_AT) begin
      held <= 1;
      hold_left <= 4000;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (sent < CALM_AFTER && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(10, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ratios_q.size() == 0) begin
        $display("%0t: result with none expected: %h %h %h %h %b", $time,
                 avg_reduction_o, ema_reduction_o, avg_baseline_o, ema_baseline_o,
                 finished_o);
        errors <= errors + 1;
      end else begin
        ratios_t e;
        e = ratios_q.pop_front();
        if (avg_reduction_o !== e.avg_red || ema_reduction_o !== e.ema_red ||
            avg_baseline_o !== e.avg_bas || ema_baseline_o !== e.ema_bas ||
            finished_o !== e.fin) begin
          $display("%0t: expected %h %h %h %h %b, got %h %h %h %h %b", $time,
                   e.avg_red, e.ema_red, e.avg_bas, e.ema_bas, e.fin,
                   avg_reduction_o, ema_reduction_o, avg_baseline_o,
                   ema_baseline_o, finished_o);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
